>>> hdl/tpd_pkg.sv
package tpd_pkg;

   // Field widths.
   localparam int BYTE_W     = 8;
   localparam int CAL_W      = 10;
   localparam int RAW_W      = 10;
   localparam int LOW_W      = 7;
   localparam int HIGH_W     = 5;
   localparam int PIX_W      = 16;
   localparam int CSR_IDX_W  = 2;

   // Shared divider: the dividend is range * |raw - edge|, the divisor is |span|.
   localparam int DIVIDEND_W = 20;
   localparam int DIVISOR_W  = 10;

   // Header decoding.
   localparam logic [BYTE_W-1:0] HDR_MASK    = 8'h81;
   localparam logic [BYTE_W-1:0] HDR_PRESS   = 8'h81;
   localparam logic [BYTE_W-1:0] HDR_RELEASE = 8'h80;

   localparam logic KIND_PRESS   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // Calibration arithmetic.
   localparam int SCREEN_OFFSET = 80;
   localparam int X_RANGE       = 640;
   localparam int Y_RANGE       = 320;
   localparam int PIX_MAX       = 32767;
   localparam int PIX_MIN       = -32768;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_RIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TOP    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_BOTTOM = 2'd3;

   localparam logic [CAL_W-1:0] CAL_LEFT_RESET   = 10'd107;
   localparam logic [CAL_W-1:0] CAL_RIGHT_RESET  = 10'd922;
   localparam logic [CAL_W-1:0] CAL_TOP_RESET    = 10'd164;
   localparam logic [CAL_W-1:0] CAL_BOTTOM_RESET = 10'd849;

   typedef struct packed {
      logic busy;
      logic done;
   } tpd_div_status_type;

endpackage

>>> hdl/tpd_channels.sv
interface tpd_req_if
   import tpd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tpd_rsp_if
   import tpd_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    event_kind;
   logic signed [PIX_W-1:0] x_pixel;
   logic signed [PIX_W-1:0] y_pixel;
   logic                    span_error;

   modport source (output valid, output event_kind, output x_pixel, output y_pixel,
                   output span_error, input ready);
   modport sink   (input valid, input event_kind, input x_pixel, input y_pixel,
                   input span_error, output ready);
endinterface

>>> hdl/tpd_divider.sv
module tpd_divider
   import tpd_pkg::*;
   #(
      parameter int DIVIDEND_WIDTH = DIVIDEND_W,
      parameter int DIVISOR_WIDTH  = DIVISOR_W
   )
   (
      input  logic                      clock,
      input  logic                      reset,
      input  logic                      start,
      input  logic [DIVIDEND_WIDTH-1:0] dividend,
      input  logic [DIVISOR_WIDTH-1:0]  divisor,
      output logic [DIVIDEND_WIDTH-1:0] quotient,
      output tpd_div_status_type        status
   );

   localparam int CNT_W = (DIVIDEND_WIDTH > 1) ? $clog2(DIVIDEND_WIDTH) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_WIDTH - 1);

   logic [DIVISOR_WIDTH:0]    rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [DIVISOR_WIDTH:0]    rem_shift;
   logic [DIVISOR_WIDTH+1:0]  trial;

   // Restoring division, one quotient bit per cycle, most significant first.
   always_comb begin
      rem_shift = {rem_ff[DIVISOR_WIDTH-1:0], quo_ff[DIVIDEND_WIDTH-1]};
      trial     = {1'b0, rem_shift} - {2'b00, dsr_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial[DIVISOR_WIDTH+1]) begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         end else begin
            rem_in = trial[DIVISOR_WIDTH:0];
            quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], 1'b1};
         end
         count_in = count_ff + CNT_W'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && count_ff == '0)
      else $error("divider did not begin after start");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff) && $past(count_ff) == LAST_STEP)
      else $error("divider finished without a full run");

endmodule

>>> hdl/touch_packet_decode_calibrate_core.sv
// Touch packet decoder with linear calibration. Bytes from the touch controller's
// serial link enter on req_ch, one per beat. A header byte with bits 7 and 0 set
// opens a pen-press packet, bit 7 alone a pen-release packet, and any other byte
// between packets is dropped. The next four bytes are x low, x high, y low and
// y high, taken as data whatever their value. Each axis is mapped through
// 80 + 640 * (raw - left) / (right - left) for x and 80 + 320 * (raw - top) /
// (bottom - top) for y, truncated toward zero and clamped to 16-bit signed; an
// axis with a zero span reads 80 and sets span_error. Bytes are taken only while
// no packet is being computed. The last byte starts two 20-step runs of one
// shared restoring divider, one per axis; the block stays not ready until the
// result is loaded into the output register, which waits while an earlier beat
// is pending. That divider sets the packet rate. While the result beat waits on
// rsp_ch, new bytes are accepted. Calibration registers are written through the
// csr_ port, indexes 0 to 3 in the order left, right, top, bottom. Write them
// only while no packet is being computed; the block does not enforce it.
module touch_packet_decode_calibrate_core
   import tpd_pkg::*;
   (
      input  logic                 clock,
      input  logic                 reset,
      tpd_req_if.sink              req_ch,
      tpd_rsp_if.source            rsp_ch,
      input  logic                 csr_write_enable,
      input  logic [CSR_IDX_W-1:0] csr_index,
      input  logic [CAL_W-1:0]     csr_write_data
   );

   // Packet collection phase.
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_X_LOW  = 3'd1;
   localparam logic [2:0] PH_X_HIGH = 3'd2;
   localparam logic [2:0] PH_Y_LOW  = 3'd3;
   localparam logic [2:0] PH_Y_HIGH = 3'd4;

   // Calibration sequencer.
   localparam logic [2:0] SEQ_IDLE    = 3'd0;
   localparam logic [2:0] SEQ_X_START = 3'd1;
   localparam logic [2:0] SEQ_X_WAIT  = 3'd2;
   localparam logic [2:0] SEQ_Y_START = 3'd3;
   localparam logic [2:0] SEQ_Y_WAIT  = 3'd4;
   localparam logic [2:0] SEQ_OUT     = 3'd5;

   localparam int DIFF_W = RAW_W + 1;
   localparam int Q_W    = DIVIDEND_W + 1;
   localparam int SUM_W  = DIVIDEND_W + 2;

   logic [CAL_W-1:0] cal_left_ff, cal_left_in;
   logic [CAL_W-1:0] cal_right_ff, cal_right_in;
   logic [CAL_W-1:0] cal_top_ff, cal_top_in;
   logic [CAL_W-1:0] cal_bottom_ff, cal_bottom_in;

   logic [2:0]        phase_ff, phase_in;
   logic [2:0]        seq_ff, seq_in;
   logic              kind_ff, kind_in;
   logic [LOW_W-1:0]  x_low_ff, x_low_in;
   logic [HIGH_W-1:0] x_high_ff, x_high_in;
   logic [LOW_W-1:0]  y_low_ff, y_low_in;
   logic [HIGH_W-1:0] y_high_ff, y_high_in;

   logic signed [PIX_W-1:0] x_pix_ff, x_pix_in;
   logic                    x_err_ff, x_err_in;
   logic signed [PIX_W-1:0] y_pix_ff, y_pix_in;
   logic                    y_err_ff, y_err_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic signed [PIX_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [PIX_W-1:0] rsp_y_ff, rsp_y_in;
   logic                    rsp_err_ff, rsp_err_in;

   logic                    req_accept;
   logic                    rsp_free;
   logic                    axis_y;
   logic [RAW_W-1:0]        raw;
   logic [CAL_W-1:0]        edge_lo;
   logic [CAL_W-1:0]        edge_hi;
   logic [DIFF_W-1:0]       diff;
   logic [DIFF_W-1:0]       span;
   logic [DIVISOR_W-1:0]    diff_mag;
   logic [DIVISOR_W-1:0]    span_mag;
   logic [DIVIDEND_W-1:0]   num_mag;
   logic                    quot_neg;
   logic                    span_zero;
   logic                    div_start;
   logic [DIVIDEND_W-1:0]   div_quotient;
   tpd_div_status_type      div_status;
   logic signed [Q_W-1:0]   q_mag;
   logic signed [Q_W-1:0]   q_signed;
   logic signed [SUM_W-1:0] pix_sum;
   logic signed [PIX_W-1:0] pix_sat;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (seq_ff == SEQ_IDLE);

   // Operands of the axis being worked on. The byte registers they come from hold
   // steady from the last byte until the result is out.
   always_comb begin
      axis_y  = (seq_ff == SEQ_Y_START) || (seq_ff == SEQ_Y_WAIT);
      raw     = axis_y ? {y_high_ff, y_low_ff[LOW_W-1:2]}
                       : {x_high_ff, x_low_ff[LOW_W-1:2]};
      edge_lo = axis_y ? cal_top_ff : cal_left_ff;
      edge_hi = axis_y ? cal_bottom_ff : cal_right_ff;
      diff    = {1'b0, raw} - {1'b0, edge_lo};
      span    = {1'b0, edge_hi} - {1'b0, edge_lo};
      diff_mag = diff[DIFF_W-1] ? DIVISOR_W'(-diff) : diff[DIVISOR_W-1:0];
      span_mag = span[DIFF_W-1] ? DIVISOR_W'(-span) : span[DIVISOR_W-1:0];
      num_mag  = DIVIDEND_W'(diff_mag) *
                 (axis_y ? DIVIDEND_W'(Y_RANGE) : DIVIDEND_W'(X_RANGE));
      quot_neg  = diff[DIFF_W-1] ^ span[DIFF_W-1];
      span_zero = (span == '0);
      div_start = (seq_ff == SEQ_X_START) || (seq_ff == SEQ_Y_START);
   end

   tpd_divider #(
      .DIVIDEND_WIDTH (DIVIDEND_W),
      .DIVISOR_WIDTH  (DIVISOR_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag),
      .divisor  (span_mag),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Sign the magnitude quotient, add the screen offset and clamp.
   always_comb begin
      q_mag    = Q_W'(div_quotient);
      q_signed = span_zero ? '0 : (quot_neg ? -q_mag : q_mag);
      pix_sum  = SUM_W'(SCREEN_OFFSET) + {q_signed[Q_W-1], q_signed};
      if (pix_sum > SUM_W'(PIX_MAX)) begin
         pix_sat = PIX_W'(PIX_MAX);
      end else if (pix_sum < SUM_W'(PIX_MIN)) begin
         pix_sat = PIX_W'(PIX_MIN);
      end else begin
         pix_sat = pix_sum[PIX_W-1:0];
      end
   end

   always_comb begin
      cal_left_in   = cal_left_ff;
      cal_right_in  = cal_right_ff;
      cal_top_in    = cal_top_ff;
      cal_bottom_in = cal_bottom_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CAL_LEFT:   cal_left_in   = csr_write_data;
            CSR_CAL_RIGHT:  cal_right_in  = csr_write_data;
            CSR_CAL_TOP:    cal_top_in    = csr_write_data;
            CSR_CAL_BOTTOM: cal_bottom_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      seq_in    = seq_ff;
      kind_in   = kind_ff;
      x_low_in  = x_low_ff;
      x_high_in = x_high_ff;
      y_low_in  = y_low_ff;
      y_high_in = y_high_ff;
      x_pix_in  = x_pix_ff;
      x_err_in  = x_err_ff;
      y_pix_in  = y_pix_ff;
      y_err_in  = y_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_err_in   = rsp_err_ff;

      if (req_accept) begin
         case (phase_ff)
            PH_X_LOW: begin
               x_low_in = req_ch.rx_byte[LOW_W-1:0];
               phase_in = PH_X_HIGH;
            end
            PH_X_HIGH: begin
               x_high_in = req_ch.rx_byte[HIGH_W-1:0];
               phase_in  = PH_Y_LOW;
            end
            PH_Y_LOW: begin
               y_low_in = req_ch.rx_byte[LOW_W-1:0];
               phase_in = PH_Y_HIGH;
            end
            PH_Y_HIGH: begin
               y_high_in = req_ch.rx_byte[HIGH_W-1:0];
               phase_in  = PH_HEADER;
               seq_in    = SEQ_X_START;
            end
            default: begin
               phase_in = PH_HEADER;
               if ((req_ch.rx_byte & HDR_MASK) == HDR_PRESS) begin
                  kind_in  = KIND_PRESS;
                  phase_in = PH_X_LOW;
               end else if ((req_ch.rx_byte & HDR_MASK) == HDR_RELEASE) begin
                  kind_in  = KIND_RELEASE;
                  phase_in = PH_X_LOW;
               end
            end
         endcase
      end

      case (seq_ff)
         SEQ_X_START: seq_in = SEQ_X_WAIT;
         SEQ_X_WAIT: begin
            if (div_status.done) begin
               x_pix_in = pix_sat;
               x_err_in = span_zero;
               seq_in   = SEQ_Y_START;
            end
         end
         SEQ_Y_START: seq_in = SEQ_Y_WAIT;
         SEQ_Y_WAIT: begin
            if (div_status.done) begin
               y_pix_in = pix_sat;
               y_err_in = span_zero;
               seq_in   = SEQ_OUT;
            end
         end
         SEQ_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_x_in     = x_pix_ff;
               rsp_y_in     = y_pix_ff;
               rsp_err_in   = x_err_ff || y_err_ff;
               seq_in       = SEQ_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      x_low_ff  <= x_low_in;
      x_high_ff <= x_high_in;
      y_low_ff  <= y_low_in;
      y_high_ff <= y_high_in;
      x_pix_ff  <= x_pix_in;
      x_err_ff  <= x_err_in;
      y_pix_ff  <= y_pix_in;
      y_err_ff  <= y_err_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_err_ff  <= rsp_err_in;
      if (reset) begin
         cal_left_ff   <= CAL_LEFT_RESET;
         cal_right_ff  <= CAL_RIGHT_RESET;
         cal_top_ff    <= CAL_TOP_RESET;
         cal_bottom_ff <= CAL_BOTTOM_RESET;
         phase_ff      <= PH_HEADER;
         seq_ff        <= SEQ_IDLE;
         kind_ff       <= KIND_PRESS;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cal_left_ff   <= cal_left_in;
         cal_right_ff  <= cal_right_in;
         cal_top_ff    <= cal_top_in;
         cal_bottom_ff <= cal_bottom_in;
         phase_ff      <= phase_in;
         seq_ff        <= seq_in;
         kind_ff       <= kind_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.event_kind = rsp_kind_ff;
   assign rsp_ch.x_pixel    = rsp_x_ff;
   assign rsp_ch.y_pixel    = rsp_y_ff;
   assign rsp_ch.span_error = rsp_err_ff;

   a_last_byte_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_Y_HIGH |=> seq_ff == SEQ_X_START)
      else $error("last packet byte did not start calibration");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> seq_ff == SEQ_X_WAIT || seq_ff == SEQ_Y_WAIT)
      else $error("divider result arrived outside a wait step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_x_ff)
                                        && $stable(rsp_y_ff))
      else $error("pending result beat was overwritten");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_ch.ready)
      else $error("bytes accepted during a division");

endmodule
